@@ rtl/core/mbt_pkg.sv @@
// shared types, constants and arithmetic helpers of the mlp training step
// no dependencies
package mbt_pkg;

  localparam int TANH_ENTRIES = 256;
  localparam int TANH_IDX_W   = $clog2(TANH_ENTRIES);

  typedef logic signed [15:0] q12_t;
  typedef logic signed [13:0] act_t;
  typedef logic [TANH_ENTRIES-1:0][15:0] tanh_tab_t;

  localparam logic [1:0] REQ_INFER = 2'd0;
  localparam logic [1:0] REQ_TRAIN = 2'd1;
  localparam logic [1:0] REQ_LOAD  = 2'd2;
  localparam logic [1:0] REQ_SPARE = 2'd3;

  localparam logic [1:0] CFG_OUT_RATE = 2'd0;
  localparam logic [1:0] CFG_HID_RATE = 2'd1;
  localparam logic [1:0] CFG_CLAMP    = 2'd2;

  // restoring long division, used only while building the table
  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q, r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], n[b]};
      if (r >= d) begin
        r    = r - d;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // tanh at bin centers, series for exp(-z) then squared four times
  function automatic tanh_tab_t build_tanh();
    tanh_tab_t   tab;
    int          s;
    logic [63:0] m, z, sum, term, den, t;
    tab = '0;
    for (int i = 0; i < TANH_ENTRIES; i++) begin
      s    = 2 * i + 1 - TANH_ENTRIES;
      m    = (s < 0) ? 64'(-s) : 64'(s);
      z    = (m << 30) >> (TANH_IDX_W + 1);
      sum  = 64'd1 << 30;
      term = 64'd1 << 30;
      for (int k = 1; k <= 14; k++) begin
        term = udiv64((term * z) >> 30, 64'(k));
        if ((k & 1) == 1) sum = sum - term;
        else sum = sum + term;
      end
      if (sum > (64'd1 << 30)) sum = 64'd1 << 30;
      for (int r = 0; r < 4; r++) sum = (sum * sum + (64'd1 << 29)) >> 30;
      den = (64'd1 << 30) + sum;
      t   = udiv64(((64'd1 << 30) - sum) * 64'd8192 + den, den << 1);
      tab[i] = (s < 0) ? 16'(-t) : 16'(t);
    end
    return tab;
  endfunction

  localparam tanh_tab_t TANH_TAB = build_tanh();

  function automatic q12_t sat16(input logic signed [31:0] v);
    if (v > 32'sd32767) return 16'sh7fff;
    if (v < -32'sd32768) return 16'sh8000;
    return v[15:0];
  endfunction

  // tanh with saturation outside [-4,4)
  function automatic act_t tanh_q12(input q12_t a);
    logic [31:0] off;
    logic [TANH_IDX_W-1:0] idx;
    off = 32'($signed({a[15], a}) + 17'sd16384);
    idx = TANH_IDX_W'((off * 32'(TANH_ENTRIES)) >> 15);
    if (a < -16'sd16384) return -14'sd4096;
    if (a >= 16'sd16384) return 14'sd4096;
    return act_t'($signed(TANH_TAB[idx]));
  endfunction

endpackage

@@ rtl/core/mbt_ifs.sv @@
// request and result channel interfaces of the mlp training step
// no dependencies
interface mbt_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        req_type;
  logic              x0;
  logic              x1;
  logic              target;
  logic [2:0]        weight_index;
  logic signed [15:0] weight_value;
  modport source (output valid, req_type, x0, x1, target, weight_index, weight_value,
                  input ready);
  modport sink (input valid, req_type, x0, x1, target, weight_index, weight_value,
                output ready);
endinterface

interface mbt_out_if;
  logic              valid;
  logic              ready;
  logic signed [15:0] net_output;
  logic signed [15:0] error_value;
  modport source (output valid, net_output, error_value, input ready);
  modport sink (input valid, net_output, error_value, output ready);
endinterface

@@ rtl/core/mbt_mul.sv @@
// shared signed 32x32 multiplier with registered product
// no dependencies beyond the package
module mbt_mul (
  input  logic               clk,
  input  logic signed [31:0] mul_a,
  input  logic signed [31:0] mul_b,
  output logic signed [63:0] mul_p
);
  import mbt_pkg::*;

  logic signed [63:0] prod_r;

  // one product per cycle, result in the next cycle
  always_ff @(posedge clk) begin
    prod_r <= 64'(mul_a) * 64'(mul_b);
  end

  assign mul_p = prod_r;

endmodule

@@ rtl/core/mlp_backprop_train_step.sv @@
// 2-2-1 tanh mlp inference and backprop training step, sequencer around one multiplier
// depends on mbt_pkg, mbt_ifs and mbt_mul
// one request at a time; train step uses 12 products, each an issue and a
// write-back state on the single shared multiplier
// reset (rst_n synchronous, active low): weights and biases zero, rates and clamp default
module mlp_backprop_train_step (
  input  logic        clk,
  input  logic        rst_n,
  mbt_in_if.sink      in_chan,
  mbt_out_if.source   out_chan,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_idx,
  input  logic [14:0] cfg_wdata
);
  import mbt_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_HID  = 5'b00010,
    S_ISS  = 5'b00100,
    S_WB   = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  localparam logic [3:0] OP_Y0 = 4'd0;
  localparam logic [3:0] OP_Y1 = 4'd1;
  localparam logic [3:0] OP_OE = 4'd2;
  localparam logic [3:0] OP_HE = 4'd3;
  localparam logic [3:0] OP_V0 = 4'd4;
  localparam logic [3:0] OP_V1 = 4'd5;
  localparam logic [3:0] OP_D0 = 4'd6;
  localparam logic [3:0] OP_D1 = 4'd7;
  localparam logic [3:0] OP_P0 = 4'd8;
  localparam logic [3:0] OP_S0 = 4'd9;
  localparam logic [3:0] OP_P1 = 4'd10;
  localparam logic [3:0] OP_S1 = 4'd11;

  state_t             state_r;
  logic [3:0]         op_r;
  logic               train_r, x0_r, x1_r, tgt_r;
  q12_t               hw_r [4];
  q12_t               hb_r [2];
  q12_t               ow_r [2];
  logic [14:0]        orate_r, hrate_r, wclamp_r;
  act_t               h_r [2];
  logic signed [31:0] acc_r, t_r, u_r, q_r;
  act_t               d_r [2];
  q12_t               y_r, e_r;
  logic               out_valid_r;
  q12_t               net_r, err_r;

  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] mul_p;

  mbt_mul u_mul (.clk(clk), .mul_a(mul_a), .mul_b(mul_b), .mul_p(mul_p));

  // hidden sums and activations
  logic signed [31:0] hsum0, hsum1;
  assign hsum0 = 32'(hb_r[0]) + (x0_r ? 32'(hw_r[0]) : 32'sd0) + (x1_r ? 32'(hw_r[1]) : 32'sd0);
  assign hsum1 = 32'(hb_r[1]) + (x0_r ? 32'(hw_r[2]) : 32'sd0) + (x1_r ? 32'(hw_r[3]) : 32'sd0);

  // operand select of the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (op_r)
      OP_Y0: begin mul_a = 32'(h_r[0]); mul_b = 32'(ow_r[0]); end
      OP_Y1: begin mul_a = 32'(h_r[1]); mul_b = 32'(ow_r[1]); end
      OP_OE: begin mul_a = 32'(e_r); mul_b = $signed({17'd0, orate_r}); end
      OP_HE: begin mul_a = 32'(e_r); mul_b = $signed({17'd0, hrate_r}); end
      OP_V0: begin mul_a = t_r; mul_b = 32'(h_r[0]); end
      OP_V1: begin mul_a = t_r; mul_b = 32'(h_r[1]); end
      OP_D0: begin mul_a = 32'(h_r[0]); mul_b = 32'(h_r[0]); end
      OP_D1: begin mul_a = 32'(h_r[1]); mul_b = 32'(h_r[1]); end
      OP_P0: begin mul_a = 32'(d_r[0]); mul_b = 32'(ow_r[0]); end
      OP_S0: begin mul_a = q_r; mul_b = u_r; end
      OP_P1: begin mul_a = 32'(d_r[1]); mul_b = 32'(ow_r[1]); end
      OP_S1: begin mul_a = q_r; mul_b = u_r; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  // write-back arithmetic
  logic signed [31:0] ysum, ysh, esum;
  q12_t               y_new;
  logic signed [63:0] vd, ss;
  logic signed [31:0] vnew, wc, dd;
  q12_t               vcl;
  logic               unit1;
  logic signed [31:0] s32;

  always_comb begin
    ysum  = acc_r + mul_p[31:0] + 32'sd2048;
    ysh   = ysum >>> 12;
    y_new = sat16(ysh);
    esum  = 32'(y_new) - (tgt_r ? 32'sd4096 : 32'sd0);
    unit1 = (op_r == OP_V1) || (op_r == OP_D1) || (op_r == OP_S1);
    vd    = (mul_p + (64'sd1 <<< 23)) >>> 24;
    wc    = $signed({17'd0, wclamp_r});
    vnew  = 32'(ow_r[unit1]) - vd[31:0];
    if (vnew > wc) vcl = wc[15:0];
    else if (vnew < -wc) vcl = 16'(-wc);
    else vcl = vnew[15:0];
    dd    = 32'sd4096 - ((mul_p[31:0] + 32'sd2048) >>> 12);
    ss    = (mul_p + (64'sd1 <<< 35)) >>> 36;
    s32   = ss[31:0];
  end

  assign in_chan.ready      = (state_r == S_IDLE);
  assign out_chan.valid       = out_valid_r;
  assign out_chan.net_output  = net_r;
  assign out_chan.error_value = err_r;

  // sequencer, state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      op_r        <= OP_Y0;
      out_valid_r <= 1'b0;
      orate_r     <= 15'd287;
      hrate_r     <= 15'd2867;
      wclamp_r    <= 15'd20480;
      for (int i = 0; i < 4; i++) hw_r[i] <= '0;
      for (int i = 0; i < 2; i++) begin
        hb_r[i] <= '0;
        ow_r[i] <= '0;
      end
    end else begin
      // configuration writes
      if (cfg_we) begin
        case (cfg_idx)
          CFG_OUT_RATE: orate_r <= cfg_wdata;
          CFG_HID_RATE: hrate_r <= cfg_wdata;
          CFG_CLAMP:    wclamp_r <= cfg_wdata;
          default: ;
        endcase
      end
      // result taken, the done state reloads the flag itself
      if (out_valid_r && out_chan.ready && state_r != S_DONE) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_chan.valid) begin
            x0_r    <= in_chan.x0;
            x1_r    <= in_chan.x1;
            tgt_r   <= in_chan.target;
            train_r <= (in_chan.req_type == REQ_TRAIN);
            op_r    <= OP_Y0;
            if (in_chan.req_type == REQ_LOAD) begin
              case (in_chan.weight_index)
                3'd0: hw_r[0] <= in_chan.weight_value;
                3'd1: hw_r[1] <= in_chan.weight_value;
                3'd2: hb_r[0] <= in_chan.weight_value;
                3'd3: hw_r[2] <= in_chan.weight_value;
                3'd4: hw_r[3] <= in_chan.weight_value;
                3'd5: hb_r[1] <= in_chan.weight_value;
                3'd6: ow_r[0] <= in_chan.weight_value;
                default: ow_r[1] <= in_chan.weight_value;
              endcase
              y_r     <= '0;
              e_r     <= '0;
              state_r <= S_DONE;
            end else begin
              state_r <= S_HID;
            end
          end
        end
        S_HID: begin
          h_r[0]  <= tanh_q12(sat16(hsum0));
          h_r[1]  <= tanh_q12(sat16(hsum1));
          state_r <= S_ISS;
        end
        S_ISS: state_r <= S_WB;
        S_WB: begin
          case (op_r)
            OP_Y0: acc_r <= mul_p[31:0];
            OP_Y1: begin
              y_r <= y_new;
              e_r <= sat16(esum);
            end
            OP_OE: t_r <= mul_p[31:0];
            OP_HE: u_r <= mul_p[31:0];
            OP_V0, OP_V1: ow_r[unit1] <= vcl;
            OP_D0, OP_D1: d_r[unit1] <= dd[13:0];
            OP_P0, OP_P1: q_r <= mul_p[31:0];
            OP_S0, OP_S1: begin
              if (x0_r) hw_r[{unit1, 1'b0}] <= sat16(32'(hw_r[{unit1, 1'b0}]) - s32);
              if (x1_r) hw_r[{unit1, 1'b1}] <= sat16(32'(hw_r[{unit1, 1'b1}]) - s32);
              hb_r[unit1] <= sat16(32'(hb_r[unit1]) - s32);
            end
            default: ;
          endcase
          if ((op_r == OP_Y1 && !train_r) || op_r == OP_S1) begin
            state_r <= S_DONE;
          end else begin
            op_r    <= op_r + 4'd1;
            state_r <= S_ISS;
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_chan.ready) begin
            net_r       <= y_r;
            err_r       <= e_r;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

@@ tb/tb_mbt.sv @@
// testbench of the mlp training step: random and directed requests, own predictor
// depends on mbt_pkg, mbt_ifs and the rtl of mlp_backprop_train_step
`timescale 1ns / 100ps

module tb;
  import mbt_pkg::*;

  typedef struct packed {
    logic [1:0]  req_type;
    logic        x0;
    logic        x1;
    logic        target;
    logic [2:0]  weight_index;
    logic [15:0] weight_value;
  } mlp_req_t;

  typedef struct packed {
    logic [15:0] net_output;
    logic [15:0] error_value;
  } mlp_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_idx = '0;
  logic [14:0] cfg_wdata = '0;

  mbt_in_if in_chan ();
  mbt_out_if out_chan ();

  mlp_backprop_train_step u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan.sink),
    .out_chan (out_chan.source),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_wdata(cfg_wdata)
  );

  // clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  mlp_req_t req_q[$];
  mlp_res_t result_q[$];
  int errors = 0;
  int send_idle = 0;
  int recv_idle = 0;
  longint cycles = 0;

  // predictor state
  logic signed [15:0] tab[TANH_ENTRIES];
  longint hw[4];
  longint hb[2];
  longint ow[2];
  longint rate_o, rate_h, clamp_v;

  function automatic longint sat(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // round half up: floor((p + 2^(s-1)) / 2^s)
  function automatic longint rnd(longint p, int s);
    return (p + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint act(longint a);
    longint idx;
    if (a < -16384) return -4096;
    if (a >= 16384) return 4096;
    idx = ((a + 16384) * TANH_ENTRIES) >>> 15;
    if (idx >= TANH_ENTRIES) idx = TANH_ENTRIES - 1;
    return tab[idx];
  endfunction

  // series for exp(-z), squared four times, as fixed point
  task automatic fill_tanh();
    longint s;
    logic [63:0] m, z, sum, term, den, t;
    for (int i = 0; i < TANH_ENTRIES; i++) begin
      s = 2 * i + 1 - TANH_ENTRIES;
      m = (s < 0) ? -s : s;
      z = (m << 30) / (2 * TANH_ENTRIES);
      sum = 64'd1 << 30;
      term = 64'd1 << 30;
      for (int k = 1; k <= 14; k++) begin
        term = ((term * z) >> 30) / k;
        if (k % 2) sum = sum - term;
        else sum = sum + term;
      end
      if (sum > (64'd1 << 30)) sum = 64'd1 << 30;
      for (int r = 0; r < 4; r++) sum = (sum * sum + (64'd1 << 29)) >> 30;
      den = (64'd1 << 30) + sum;
      t = (((64'd1 << 30) - sum) * 64'd8192 + den) / (64'd2 * den);
      tab[i] = (s < 0) ? -$signed(t[15:0]) : $signed(t[15:0]);
    end
  endtask

  task automatic reset_net();
    foreach (hw[i]) hw[i] = 0;
    foreach (hb[i]) begin
      hb[i] = 0;
      ow[i] = 0;
    end
    rate_o = 287;
    rate_h = 2867;
    clamp_v = 20480;
  endtask

  // expected net output and error, with weight updates
  function automatic mlp_res_t predict_step(mlp_req_t r);
    mlp_res_t res;
    longint x[2], h[2], a, acc, y, e, d, v, s;
    x[0] = r.x0;
    x[1] = r.x1;
    res = '0;
    if (r.req_type == REQ_LOAD) begin
      v = $signed(r.weight_value);
      case (r.weight_index)
        3'd0, 3'd1: hw[r.weight_index] = v;
        3'd2: hb[0] = v;
        3'd3, 3'd4: hw[r.weight_index - 1] = v;
        3'd5: hb[1] = v;
        default: ow[r.weight_index - 6] = v;
      endcase
      return res;
    end
    acc = 0;
    for (int i = 0; i < 2; i++) begin
      a = hb[i];
      for (int j = 0; j < 2; j++) if (x[j] != 0) a += hw[2 * i + j];
      h[i] = act(sat(a));
      acc += h[i] * ow[i];
    end
    y = sat(rnd(acc, 12));
    e = sat(y - longint'(r.target) * 4096);
    if (r.req_type == REQ_TRAIN) begin
      for (int i = 0; i < 2; i++) begin
        d = rnd(rate_o * e * h[i], 24);
        v = ow[i] - d;
        if (v > clamp_v) v = clamp_v;
        if (v < -clamp_v) v = -clamp_v;
        ow[i] = v;
      end
      for (int i = 0; i < 2; i++) begin
        d = 4096 - rnd(h[i] * h[i], 12);
        s = rnd(d * ow[i] * e * rate_h, 36);
        for (int j = 0; j < 2; j++)
          if (x[j] != 0) hw[2 * i + j] = sat(hw[2 * i + j] - s);
        hb[i] = sat(hb[i] - s);
      end
    end
    res.net_output = y[15:0];
    res.error_value = e[15:0];
    return res;
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
    end else if (!in_chan.valid || in_chan.ready) begin
      if (req_q.size() > 0 && $urandom_range(99) >= send_idle) begin
        result_q.push_back(predict_step(req_q[0]));
        {in_chan.req_type, in_chan.x0, in_chan.x1, in_chan.target,
         in_chan.weight_index, in_chan.weight_value} <= req_q.pop_front();
        in_chan.valid <= 1'b1;
      end else begin
        in_chan.valid <= 1'b0;
      end
    end
  end

  // receiver stall
  always @(posedge clk) begin
    out_chan.ready <= rst_n && ($urandom_range(99) >= recv_idle);
  end

  // monitor
  always @(posedge clk) begin
    mlp_res_t exp_r;
    cycles <= cycles + 1;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (result_q.size() == 0) begin
        $error("unexpected result %h %h", out_chan.net_output, out_chan.error_value);
        errors = errors + 1;
      end else begin
        exp_r = result_q.pop_front();
        if (out_chan.net_output !== exp_r.net_output) begin
          $error("net_output exp %h got %h", exp_r.net_output, out_chan.net_output);
          errors = errors + 1;
        end
        if (out_chan.error_value !== exp_r.error_value) begin
          $error("error_value exp %h got %h", exp_r.error_value, out_chan.error_value);
          errors = errors + 1;
        end
      end
    end
  end

  // timeout
  always @(posedge clk) begin
    if (cycles > 400000) begin
      $display("tb: errors");
      $finish;
    end
  end

  function automatic mlp_req_t mk_req(logic [1:0] t, logic [2:0] wi, logic [15:0] wv);
    mlp_req_t r;
    r.req_type = t;
    r.x0 = 1'($urandom_range(1));
    r.x1 = 1'($urandom_range(1));
    r.target = 1'($urandom_range(1));
    r.weight_index = wi;
    r.weight_value = wv;
    return r;
  endfunction

  task automatic drain();
    wait (req_q.size() == 0 && result_q.size() == 0);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_cfg(logic [1:0] idx, logic [14:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_OUT_RATE: rate_o = val;
      CFG_HID_RATE: rate_h = val;
      CFG_CLAMP: clamp_v = val;
      default: ;
    endcase
  endtask

  // random phase: mostly training, some sane and some wild loads, inference and spare
  task automatic random_phase(int n);
    int k;
    for (k = 0; k < n; k++) begin
      case ($urandom_range(9))
        0: req_q.push_back(mk_req(REQ_LOAD, 3'($urandom_range(7)), 16'($urandom)));
        1: req_q.push_back(mk_req(REQ_LOAD, 3'($urandom_range(7)),
                                  16'($signed($urandom_range(8192)) - 4096)));
        2: req_q.push_back(mk_req(REQ_INFER, 3'd0, 16'($urandom)));
        3: req_q.push_back(mk_req(REQ_SPARE, 3'($urandom_range(7)), 16'($urandom)));
        default: req_q.push_back(mk_req(REQ_TRAIN, 3'($urandom_range(7)), 16'($urandom)));
      endcase
    end
  endtask

  initial begin
    logic [15:0] edge_vals[4];
    fill_tanh();
    reset_net();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed: extreme loads in every slot, each request type
    edge_vals = '{16'h7fff, 16'h8000, 16'h0000, 16'hffff};
    for (int i = 0; i < 8; i++)
      req_q.push_back(mk_req(REQ_LOAD, 3'(i), edge_vals[2'(i)]));
    req_q.push_back(mk_req(REQ_INFER, 3'd0, 16'd0));
    req_q.push_back(mk_req(REQ_TRAIN, 3'd0, 16'd0));
    req_q.push_back(mk_req(REQ_SPARE, 3'd7, 16'h5555));
    for (int i = 0; i < 8; i++)
      req_q.push_back(mk_req(REQ_LOAD, 3'(i), 16'($signed($urandom_range(6000)) - 3000)));
    for (int i = 0; i < 6; i++) req_q.push_back(mk_req(REQ_TRAIN, 3'd0, 16'haaaa));
    drain();
    write_cfg(CFG_OUT_RATE, 15'h7fff);
    write_cfg(CFG_HID_RATE, 15'h7fff);
    write_cfg(CFG_CLAMP, 15'd0);
    write_cfg(2'd3, 15'h1234);
    send_idle = 11;
    recv_idle = 83;
    random_phase(120);
    drain();
    write_cfg(CFG_OUT_RATE, 15'd0);
    write_cfg(CFG_HID_RATE, 15'd0);
    write_cfg(CFG_CLAMP, 15'h7fff);
    send_idle = 83;
    recv_idle = 11;
    random_phase(120);
    drain();
    write_cfg(CFG_OUT_RATE, 15'd287);
    write_cfg(CFG_HID_RATE, 15'd2867);
    write_cfg(CFG_CLAMP, 15'd20480);
    send_idle = 0;
    recv_idle = 0;
    random_phase(460);
    drain();
    if (errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end
endmodule
